// ----- hdl/msd_pkg.sv -----
// Package for the multi-server dispatch block: sizes, event codes, register
// indexes and the types shared by the dispatch logic and the top level.
// No dependencies.
`timescale 1ns / 1ps

package msd_pkg;

  // Sizing
  localparam int CHANNELS    = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int TIME_W      = 32;
  localparam int JOB_W       = 14;
  localparam int SVC_W       = 24;
  localparam int CH_W        = 2;
  localparam int NREGS       = 3;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);

  // Configuration register indexes
  localparam logic [1:0] REG_SVC0 = 2'd0;
  localparam logic [1:0] REG_SVC1 = 2'd1;
  localparam logic [1:0] REG_SVC2 = 2'd2;

  // Reset service durations in ticks (10 h, 5 h, 5 h at 256 ticks per hour)
  localparam logic [SVC_W-1:0] SVC0_RST = SVC_W'(2560);
  localparam logic [SVC_W-1:0] SVC1_RST = SVC_W'(1280);
  localparam logic [SVC_W-1:0] SVC2_RST = SVC_W'(1280);

  typedef enum logic [1:0] {
    EV_QSTART = 2'd0,
    EV_START  = 2'd1,
    EV_QUEUED = 2'd2,
    EV_DROP   = 2'd3
  } msd_kind_t;

  typedef logic [CHANNELS-1:0][TIME_W-1:0] msd_starts_t;
  typedef logic [CHANNELS-1:0][SVC_W-1:0]  msd_durs_t;

  // Dispatch decision for one arrival
  typedef struct packed {
    logic            pop;
    logic [CH_W-1:0] pop_ch;
    logic            place;
    logic [CH_W-1:0] place_ch;
    logic            push;
  } msd_dec_t;

  // One result item
  typedef struct packed {
    msd_kind_t        kind;
    logic [JOB_W-1:0] job;
    logic [CH_W-1:0]  ch;
    logic             last;
  } msd_result_t;

endpackage

// ----- hdl/msd_dispatch.sv -----
// Dispatch decision: free-channel checks, first-free selection for the queued
// head job and for the arrival, and the queue/drop choice.
// Depends on msd_pkg.
`timescale 1ns / 1ps

module msd_dispatch (
  input  logic [msd_pkg::TIME_W-1:0] arr_time,
  input  msd_pkg::msd_starts_t       starts,
  input  msd_pkg::msd_durs_t         durs,
  input  logic [msd_pkg::CNT_W-1:0]  count,
  output msd_pkg::msd_dec_t          dec
);
  import msd_pkg::*;

  logic [CHANNELS-1:0] free;
  logic [CHANNELS-1:0] free2;
  logic [TIME_W:0]     diff [CHANNELS];
  logic                any1;
  logic [CH_W-1:0]     first1;
  logic                any2;
  logic [CH_W-1:0]     first2;
  logic                pop;
  logic [CNT_W-1:0]    count_pop;

  // A channel is free when the elapsed time is non-negative and exceeds its duration
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      diff[c] = {1'b0, arr_time} - {1'b0, starts[c]};
      free[c] = !diff[c][TIME_W] && (diff[c][TIME_W-1:0] > {{(TIME_W-SVC_W){1'b0}}, durs[c]});
    end
  end

  // Pick the first free channel for the queued head job
  always_comb begin
    any1   = 1'b0;
    first1 = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (free[c]) begin
        any1   = 1'b1;
        first1 = CH_W'(c);
      end
    end
  end

  // Pop the head job when a channel is free and the queue holds jobs
  assign pop = any1 && (count != '0);

  // Mark the popped job's channel busy, then pick again for the arrival
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      free2[c] = free[c] && !(pop && (first1 == CH_W'(c)));
    end
    any2   = 1'b0;
    first2 = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (free2[c]) begin
        any2   = 1'b1;
        first2 = CH_W'(c);
      end
    end
  end

  assign count_pop = count - CNT_W'(pop);

  assign dec.pop      = pop;
  assign dec.pop_ch   = first1;
  assign dec.place    = any2;
  assign dec.place_ch = first2;
  assign dec.push     = !any2 && (count_pop < DEPTH_CNT);

endmodule

// ----- hdl/multi_server_dispatch_bounded_queue_core.sv -----
// Multi-server dispatch with a bounded job queue.
// An accepted item waits in the input register until the result register can
// take its results, which are then loaded into the result register and offered
// on the event channel from there. Throughput: one item per cycle when it yields
// one result and out_ready is held high; an item that yields two results holds
// the next one back until its first result is taken (set by the single result port).
// Reset (synchronous): clears channel start times, queue pointers and handshake
// state, and loads the default service durations. Queue storage is not cleared.
`timescale 1ns / 1ps

module multi_server_dispatch_bounded_queue_core (
  input  logic                        clk,
  input  logic                        rst,
  // arrival channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [msd_pkg::TIME_W-1:0]  arrival_time,
  input  logic [msd_pkg::JOB_W-1:0]   job_id,
  input  logic                        restart,
  // event channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  event_kind,
  output logic [msd_pkg::JOB_W-1:0]   event_job,
  output logic [msd_pkg::CH_W-1:0]    channel_index,
  output logic                        last_event,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import msd_pkg::*;

  // Configuration registers
  logic [SVC_W-1:0] svc [NREGS];

  // Input register
  logic              in_v;
  logic [TIME_W-1:0] in_t;
  logic [JOB_W-1:0]  in_job;
  logic              in_rst;

  // Dispatch state
  logic [TIME_W-1:0] channel_start [CHANNELS];
  logic [JOB_W-1:0]  fifo_store [QUEUE_DEPTH];
  logic [IDX_W-1:0]  fifo_head;
  logic [CNT_W-1:0]  fifo_count;

  // Result register, two deep
  msd_result_t res0;
  msd_result_t res1;
  logic [1:0]  res_cnt;

  logic        fire;
  logic        take;
  msd_starts_t starts_eff;
  msd_durs_t   durs;
  logic [IDX_W-1:0] head_eff;
  logic [CNT_W-1:0] count_eff;
  msd_dec_t    dec;
  logic [JOB_W-1:0] pop_job;
  logic [IDX_W-1:0] fifo_head_next;
  logic [CNT_W-1:0] count_pop;
  logic [CNT_W-1:0] fifo_count_next;
  logic [CNT_W:0]   tail_sum;
  logic [IDX_W-1:0] tail;
  msd_result_t arr_res;
  msd_result_t new0;
  msd_result_t new1;
  logic [1:0]  new_cnt;
  logic [1:0]  cfg_idx;
  logic        cfg_wr;

  // Handshakes
  assign take     = out_valid && out_ready;
  assign fire     = in_v && ((res_cnt == 2'd0) || ((res_cnt == 2'd1) && out_ready));
  assign in_ready = !in_v || fire;

  // Effective state after an optional restart
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      starts_eff[c] = in_rst ? '0 : channel_start[c];
      durs[c]       = svc[c];
    end
  end
  assign head_eff  = in_rst ? '0 : fifo_head;
  assign count_eff = in_rst ? '0 : fifo_count;

  msd_dispatch u_dispatch (
    .arr_time (in_t),
    .starts   (starts_eff),
    .durs     (durs),
    .count    (count_eff),
    .dec      (dec)
  );

  // Queue pointer updates: pop advances the head, push writes at the tail
  assign pop_job        = fifo_store[head_eff];
  assign fifo_head_next = !dec.pop ? head_eff :
                          (head_eff == LAST_IDX) ? '0 : head_eff + IDX_W'(1);
  assign count_pop      = count_eff - CNT_W'(dec.pop);
  assign tail_sum       = {{(CNT_W + 1 - IDX_W){1'b0}}, fifo_head_next} + {1'b0, count_pop};
  assign tail           = (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
                          ? IDX_W'(tail_sum - (CNT_W + 1)'(QUEUE_DEPTH))
                          : IDX_W'(tail_sum);
  assign fifo_count_next = count_pop + CNT_W'(dec.push);

  // Build the result items for this arrival
  always_comb begin
    arr_res.job  = in_job;
    arr_res.last = 1'b1;
    priority if (dec.place) begin
      arr_res.kind = EV_START;
      arr_res.ch   = dec.place_ch;
    end else if (dec.push) begin
      arr_res.kind = EV_QUEUED;
      arr_res.ch   = '0;
    end else begin
      arr_res.kind = EV_DROP;
      arr_res.ch   = '0;
    end
    if (dec.pop) begin
      new0.kind = EV_QSTART;
      new0.job  = pop_job;
      new0.ch   = dec.pop_ch;
      new0.last = 1'b0;
      new1      = arr_res;
      new_cnt   = 2'd2;
    end else begin
      new0    = arr_res;
      new1    = arr_res;
      new_cnt = 2'd1;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v <= 1'b1;
    end else if (fire) begin
      in_v <= 1'b0;
    end
    if (in_valid && in_ready) begin
      in_t   <= arrival_time;
      in_job <= job_id;
      in_rst <= restart;
    end
  end

  // Dispatch state: channel start times and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        channel_start[c] <= '0;
      end
      fifo_head  <= '0;
      fifo_count <= '0;
    end else if (fire) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if ((dec.pop && (dec.pop_ch == CH_W'(c))) ||
            (dec.place && (dec.place_ch == CH_W'(c)))) begin
          channel_start[c] <= in_t;
        end else begin
          channel_start[c] <= starts_eff[c];
        end
      end
      fifo_head  <= fifo_head_next;
      fifo_count <= fifo_count_next;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (fire && dec.push) begin
      fifo_store[tail] <= in_job;
    end
  end

  // Result register: load a new pair, or advance the second item
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
    end else if (fire) begin
      res_cnt <= new_cnt;
    end else if (take) begin
      res_cnt <= res_cnt - 2'd1;
    end
    if (fire) begin
      res0 <= new0;
      res1 <= new1;
    end else if (take) begin
      res0 <= res1;
    end
  end

  assign out_valid     = (res_cnt != 2'd0);
  assign event_kind    = res0.kind;
  assign event_job     = res0.job;
  assign channel_index = res0.ch;
  assign last_event    = res0.last;

  // Configuration writes
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      svc[0] <= SVC0_RST;
      svc[1] <= SVC1_RST;
      svc[2] <= SVC2_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SVC0: svc[0] <= pwdata[SVC_W-1:0];
        REG_SVC1: svc[1] <= pwdata[SVC_W-1:0];
        REG_SVC2: svc[2] <= pwdata[SVC_W-1:0];
        default: ;
      endcase
    end
  end

  // Configuration reads
  always_comb begin
    unique case (cfg_idx)
      REG_SVC0: prdata = {{(32 - SVC_W){1'b0}}, svc[0]};
      REG_SVC1: prdata = {{(32 - SVC_W){1'b0}}, svc[1]};
      REG_SVC2: prdata = {{(32 - SVC_W){1'b0}}, svc[2]};
      default:  prdata = '0;
    endcase
  end

endmodule
